@@ sv/hee_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and entity tables for the html entity encoder
// no dependencies

package hee_pkg;

    localparam int CP_W        = 21;
    localparam int NUM_DIGITS  = 7;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CP_W-1:0] ASCII_MAX = 21'd127;

    // divide by ten: q = (r * 838861) >> 23, exact for r below 2**22
    localparam logic [19:0] DIV10_MAGIC = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    localparam int          ADDR_W           = 3;
    localparam logic        REG_ESCAPE_QUOTE = 1'b0;
    localparam logic        REG_ESCAPE_TAGS  = 1'b1;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        KIND_BYTE,
        KIND_QUOT,
        KIND_LT,
        KIND_GT,
        KIND_AMP,
        KIND_NUM
    } kind_t;

    typedef logic [3:0] digit_t;

    // one classified character, digits least significant first
    typedef struct packed {
        kind_t                      kind;
        logic [7:0]                 ch;
        digit_t [NUM_DIGITS-1:0]    digits;
        logic [2:0]                 ndig;
    } entry_t;

    // byte of a named entity at a given position
    function automatic logic [7:0] entity_byte(kind_t kind, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = CH_SEMI;
        unique case (kind)
            KIND_QUOT: begin
                case (idx)
                    4'd0:    b = CH_AMP;
                    4'd1:    b = "q";
                    4'd2:    b = "u";
                    4'd3:    b = "o";
                    4'd4:    b = "t";
                    default: b = CH_SEMI;
                endcase
            end
            KIND_LT: begin
                case (idx)
                    4'd0:    b = CH_AMP;
                    4'd1:    b = "l";
                    4'd2:    b = "t";
                    default: b = CH_SEMI;
                endcase
            end
            KIND_GT: begin
                case (idx)
                    4'd0:    b = CH_AMP;
                    4'd1:    b = "g";
                    4'd2:    b = "t";
                    default: b = CH_SEMI;
                endcase
            end
            KIND_AMP: begin
                case (idx)
                    4'd0:    b = CH_AMP;
                    4'd1:    b = "a";
                    4'd2:    b = "m";
                    4'd3:    b = "p";
                    default: b = CH_SEMI;
                endcase
            end
            default: b = CH_SEMI;
        endcase
        return b;
    endfunction

    // position of the closing semicolon of a named entity
    function automatic logic [IDX_W-1:0] entity_last(kind_t kind);
        logic [IDX_W-1:0] n;
        n = 4'd0;
        unique case (kind)
            KIND_QUOT: n = 4'd5;
            KIND_LT:   n = 4'd3;
            KIND_GT:   n = 4'd3;
            KIND_AMP:  n = 4'd4;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/hee_front.sv @@
`timescale 1ns / 1ps
// front end: accepts code points, classifies them, converts large ones to decimal
// depends on hee_pkg

module hee_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [hee_pkg::CP_W-1:0] in_code_point,
    input  logic                  esc_quote,
    input  logic                  esc_tags,
    output logic                  push_valid,
    input  logic                  push_ready,
    output hee_pkg::entry_t       push_entry
);
    import hee_pkg::*;

    logic                          busy_reg, busy_next;
    logic [CP_W-1:0]               rem_reg, rem_next;
    logic [2:0]                    nd_reg, nd_next;
    digit_t [NUM_DIGITS-1:0]       digits_reg, digits_next;

    logic [40:0]                   prod;
    logic [CP_W-1:0]               quo;
    logic [23:0]                   tens;
    logic [23:0]                   diff;
    digit_t                        dig;
    logic                          last_step;
    digit_t [NUM_DIGITS-1:0]       merged;
    logic                          is_num;
    entry_t                        plain_entry;
    entry_t                        num_entry;

    // one decimal digit per cycle; the last digit is held until the queue takes the entry
    always_comb begin
        prod      = 41'(rem_reg) * 41'(DIV10_MAGIC);
        quo       = CP_W'(prod >> DIV10_SHIFT);
        tens      = {quo, 3'b000} + {2'b00, quo, 1'b0};
        diff      = {3'b000, rem_reg} - tens;
        dig       = diff[3:0];
        last_step = (quo == '0);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            merged[i] = (nd_reg == 3'(i)) ? dig : digits_reg[i];
        end
    end

    always_comb begin
        is_num             = (in_code_point > ASCII_MAX);
        plain_entry.ch     = in_code_point[7:0];
        plain_entry.digits = '0;
        plain_entry.ndig   = '0;
        if (in_code_point[7:0] == CH_QUOTE && esc_quote) begin
            plain_entry.kind = KIND_QUOT;
        end else if (in_code_point[7:0] == CH_LT && esc_tags) begin
            plain_entry.kind = KIND_LT;
        end else if (in_code_point[7:0] == CH_GT && esc_tags) begin
            plain_entry.kind = KIND_GT;
        end else if (in_code_point[7:0] == CH_AMP) begin
            plain_entry.kind = KIND_AMP;
        end else begin
            plain_entry.kind = KIND_BYTE;
        end

        num_entry.kind   = KIND_NUM;
        num_entry.ch     = '0;
        num_entry.digits = merged;
        num_entry.ndig   = nd_reg + 3'd1;
    end

    assign in_ready   = !busy_reg && push_ready;
    assign push_valid = busy_reg ? last_step : (in_valid && !is_num);
    assign push_entry = busy_reg ? num_entry : plain_entry;

    always_comb begin
        busy_next   = busy_reg;
        rem_next    = rem_reg;
        nd_next     = nd_reg;
        digits_next = digits_reg;
        if (busy_reg) begin
            if (!last_step) begin
                rem_next    = quo;
                nd_next     = nd_reg + 3'd1;
                digits_next = merged;
            end else if (push_ready) begin
                busy_next = 1'b0;
            end
        end else if (in_valid && in_ready && is_num) begin
            busy_next = 1'b1;
            rem_next  = in_code_point;
            nd_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg    <= rem_next;
        nd_reg     <= nd_next;
        digits_reg <= digits_next;
    end

endmodule

@@ sv/hee_queue.sv @@
`timescale 1ns / 1ps
// two-entry queue of classified characters between front and back end
// depends on hee_pkg

module hee_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  hee_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop,
    output hee_pkg::entry_t pop_entry
);
    import hee_pkg::*;

    entry_t     mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/hee_back.sv @@
`timescale 1ns / 1ps
// back end: serializes one classified character into its byte run
// depends on hee_pkg

module hee_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  hee_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import hee_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] semi_idx;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic             load;

    // digits stored lsd first, emitted msd first after "&#"
    always_comb begin
        pos      = IDX_W'(q_entry.ndig) + 4'd1 - idx_reg;
        semi_idx = IDX_W'(q_entry.ndig) + 4'd2;
        cur_byte = q_entry.ch;
        cur_last = 1'b1;
        case (q_entry.kind) inside
            KIND_QUOT, KIND_LT, KIND_GT, KIND_AMP: begin
                cur_byte = entity_byte(q_entry.kind, idx_reg);
                cur_last = (idx_reg == entity_last(q_entry.kind));
            end
            KIND_NUM: begin
                cur_last = (idx_reg == semi_idx);
                if (idx_reg == 4'd0) begin
                    cur_byte = CH_AMP;
                end else if (idx_reg == 4'd1) begin
                    cur_byte = CH_HASH;
                end else if (cur_last) begin
                    cur_byte = CH_SEMI;
                end else begin
                    cur_byte = CH_ZERO + {4'b0000, q_entry.digits[pos[2:0]]};
                end
            end
            default: begin
                cur_byte = q_entry.ch;
                cur_last = 1'b1;
            end
        endcase
    end

    assign load  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = load && cur_last;

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = cur_last;
            idx_next       = cur_last ? '0 : idx_reg + 4'd1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // a run never exceeds ten bytes
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= 4'd9)
        else $error("run position out of range");

    // the beat that retires a queue entry is flagged last
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (out_valid_reg && out_last_reg))
        else $error("entry retired without last beat");

    // the next run starts from its first byte
    a_pop_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (idx_reg == '0))
        else $error("run position not rewound");

endmodule

@@ sv/html_entity_encoder.sv @@
`timescale 1ns / 1ps
// top level of the html entity encoder: config registers, front end, queue, back end
// depends on hee_pkg, hee_front, hee_queue, hee_back
//
//  channel  | dir | beat contents                         | handshake
//  ---------+-----+---------------------------------------+--------------------------
//  s_       | in  | code_point (21 bits) in s_tdata[20:0] | s_tvalid / s_tready
//  m_       | out | out_byte in m_tdata, run_last m_tlast | m_tvalid / m_tready
//  apb      | in  | escape_quote @0x0, escape_tags @0x4   | psel / penable, pready = 1
//
// a character up to 127 that is not escaped becomes a single byte; the back end emits one
// byte per cycle while m_tready is high and the queue holds an entry; an entity is 4 to 10 bytes
// a code point above 127 is split into its decimal digits (3 to 7), one per cycle, in the
// front end's divide-by-ten unit, overlapped with the back end draining the previous run
// a two-entry queue lets the front end keep accepting while m_tready is low, until the queue is full
// reset is synchronous, active low; both escape enables come out of reset set

module html_entity_encoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input beats
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [20:0] code_point, [23:21] zero
    // output beats
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,   // run_last
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hee_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import hee_pkg::*;

    logic   esc_quote_reg, esc_quote_next;
    logic   esc_tags_reg, esc_tags_next;
    logic   cfg_write;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop;
    entry_t pop_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // register decode, only the word address matters
    always_comb begin
        esc_quote_next = esc_quote_reg;
        esc_tags_next  = esc_tags_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_ESCAPE_QUOTE: esc_quote_next = pwdata[0];
                REG_ESCAPE_TAGS:  esc_tags_next  = pwdata[0];
                default:          esc_quote_next = esc_quote_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ESCAPE_QUOTE: prdata = {31'b0, esc_quote_reg};
            REG_ESCAPE_TAGS:  prdata = {31'b0, esc_tags_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_quote_reg <= 1'b1;
            esc_tags_reg  <= 1'b1;
        end else begin
            esc_quote_reg <= esc_quote_next;
            esc_tags_reg  <= esc_tags_next;
        end
    end

    // classify and convert
    hee_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_code_point (s_tdata[CP_W-1:0]),
        .esc_quote     (esc_quote_reg),
        .esc_tags      (esc_tags_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    // decouples classification from serialization
    hee_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    // byte serializer with registered output
    hee_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (pop_valid),
        .q_entry   (pop_entry),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
